### hw/rtl/irq_number_range_allocator_defines.svh
// Assertion macros for the interrupt number range allocator.
// Included by the RTL files that carry assertions; depends on nothing.
`ifndef IRQ_NUMBER_RANGE_ALLOCATOR_DEFINES_SVH
`define IRQ_NUMBER_RANGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define IRA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IRA_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IRA_ASSERT(label, clk, rst_n, prop, msg)
`define IRA_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### hw/rtl/ira_pkg.sv
// Shared constants for the interrupt number range allocator.
// No dependencies.
package ira_pkg;
    localparam int MAP_BITS = 1024;
    localparam int INITIAL_LIMIT = 16;
    localparam int WORD_BITS = 32;
    localparam int WORDS = MAP_BITS / WORD_BITS;
    localparam int WADDR_W = $clog2(WORDS);
    localparam int BIT_W = $clog2(WORD_BITS);
    localparam int NUM_W = $clog2(MAP_BITS) + 1;
    localparam int CMD_W = 3;
    localparam int ST_W = 2;
    localparam int FIELD_W = 11;
    localparam int IN_W = 10;

    localparam logic [CMD_W-1:0] CMD_ALLOC_ANY = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC_FIXED = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEXT = 3'd4;

    localparam logic [ST_W-1:0] ST_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_TAKEN = 2'd2;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd3;

    localparam logic [NUM_W-1:0] LIMIT_RESET =
        NUM_W'((INITIAL_LIMIT > MAP_BITS) ? MAP_BITS : INITIAL_LIMIT);

    typedef logic [NUM_W-1:0] num_t;
endpackage

### hw/rtl/irq_number_range_allocator.sv
// Interrupt number range allocator: one item in, one result out. The bitmap sits in a memory of
// MAP_BITS/32 words with a registered read. Each item makes a scan pass over all words, then a
// decision state and a hand-off state; a successful allocation, free or reserve puts a second
// read-modify-write pass between them that updates the map. The hand-off waits only while an
// earlier result is still unaccepted. The next item can be taken in the cycle after the result
// is loaded, even while that result waits. After reset the map memory is swept clear word by
// word, during which no item is accepted. Depends on ira_pkg and the defines header.
`include "irq_number_range_allocator_defines.svh"
module irq_number_range_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ira_pkg::CMD_W-1:0]  command,
    input  logic [ira_pkg::IN_W-1:0]   fixed_number,
    input  logic [ira_pkg::IN_W-1:0]   from_number,
    input  logic [ira_pkg::FIELD_W-1:0] count,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ira_pkg::ST_W-1:0]   status,
    output logic [ira_pkg::FIELD_W-1:0] number,
    output logic [ira_pkg::FIELD_W-1:0] active_count
);
    import ira_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rdata_reg;

    logic [2:0] state_reg, state_next;
    logic [WADDR_W:0] addr_reg, addr_next;   // word issue counter
    logic rvld_reg;                          // rdata_reg holds a word
    logic [WADDR_W-1:0] raddr_reg;           // word index of rdata_reg
    logic [CMD_W-1:0] cmd_reg;
    num_t from_reg, cnt_reg, fix_reg;
    num_t limit_reg, limit_next;
    // scan results
    num_t run_reg, run_next;
    num_t start_reg, start_next;
    logic found_reg, found_next;
    num_t nxt_reg, nxt_next;
    logic nfound_reg, nfound_next;
    // write pass
    logic wr_en;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    num_t wlo_reg, whi_reg;                  // range [wlo, whi)
    logic wval_reg;
    logic [ST_W-1:0] st_reg, st_next;
    num_t num_reg, num_next;
    logic ovld_reg;
    logic [ST_W-1:0] ost_reg;
    num_t onum_reg, olim_reg;
    logic out_load;
    logic [WADDR_W:0] rd_addr;
    logic rd_en;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = ovld_reg;
    assign status = ost_reg;
    assign number = FIELD_W'(onum_reg);
    assign active_count = FIELD_W'(olim_reg);
    assign out_load = (state_reg == S_DONE) && (!ovld_reg || out_ready);

    // Memory: one read and one write port, read data registered.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr[WADDR_W-1:0]];
        end
    end

    // Per-word scan of the word in rdata_reg. The run length at each bit is taken from the
    // nearest blocking bit below it, so no adder depends on another.
    always_comb
    begin
        num_t lo, b, s, nx;
        logic f, nf, hit;
        logic [BIT_W-1:0] lastz;
        logic [WORD_BITS-1:0] z;
        num_t runv [WORD_BITS];
        lo = (cmd_reg == CMD_ALLOC_FIXED) ? fix_reg : from_reg;
        f = found_reg; s = start_reg; nf = nfound_reg; nx = nxt_reg;
        hit = 1'b0;
        lastz = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            b = num_t'({raddr_reg, BIT_W'(i)});
            // Bits below the search start only occur before it, where the run is zero anyway.
            z[i] = (b < lo) || rdata_reg[i] || (cmd_reg == CMD_RESERVE && b >= limit_reg);
            if (z[i])
            begin
                hit = 1'b1;
                lastz = BIT_W'(i);
            end
            runv[i] = hit ? num_t'(BIT_W'(i) - lastz) : run_reg + num_t'(i + 1);
            if (!f && !z[i] && runv[i] == cnt_reg)
            begin
                f = 1'b1;
                s = b + 1'b1 - cnt_reg;
            end
            if (b >= from_reg && b < limit_reg && !nf && rdata_reg[i])
            begin
                nf = 1'b1;
                nx = b;
            end
        end
        run_next = runv[WORD_BITS-1]; found_next = f; start_next = s;
        nfound_next = nf; nxt_next = nx;
    end

    // Write pass: rewrite each word with its read data, bits in [wlo, whi) set to wval; zero while clearing.
    always_comb
    begin
        num_t b;
        wr_data = rdata_reg;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            b = num_t'({raddr_reg, BIT_W'(i)});
            if (b >= wlo_reg && b < whi_reg)
            begin
                wr_data[i] = wval_reg;
            end
        end
        if (state_reg == S_CLEAR)
        begin
            wr_data = '0;
        end
    end

    always_comb
    begin
        num_t endn;
        logic [NUM_W:0] rend;
        state_next = state_reg;
        addr_next = addr_reg;
        limit_next = limit_reg;
        st_next = st_reg;
        num_next = num_reg;
        rd_en = 1'b0;
        rd_addr = addr_reg;
        wr_en = 1'b0;
        wr_addr = raddr_reg;
        endn = start_reg + cnt_reg;
        rend = {1'b0, from_reg} + {1'b0, cnt_reg};
        case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                wr_addr = addr_reg[WADDR_W-1:0];
                addr_next = addr_reg + 1'b1;
                if (addr_reg == (WADDR_W+1)'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                addr_next = '0;
                if (in_valid && in_ready)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (addr_reg < (WADDR_W+1)'(WORDS))
                begin
                    rd_en = 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
                else if (!rvld_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                st_next = ST_INVALID;
                num_next = '0;
                case (cmd_reg)
                    CMD_ALLOC_ANY, CMD_ALLOC_FIXED:
                    begin
                        if (cnt_reg == '0
                            || (cmd_reg == CMD_ALLOC_FIXED && fix_reg < from_reg))
                        begin
                            st_next = ST_INVALID;
                        end
                        else if (!found_reg
                                 || (cmd_reg == CMD_ALLOC_FIXED && start_reg != fix_reg))
                        begin
                            st_next = (cmd_reg == CMD_ALLOC_FIXED) ? ST_TAKEN : ST_NOSPACE;
                        end
                        else
                        begin
                            st_next = ST_OK;
                            num_next = start_reg;
                            if (endn > limit_reg)
                            begin
                                limit_next = endn;
                            end
                            state_next = S_WRITE;
                        end
                    end
                    CMD_FREE:
                    begin
                        num_next = from_reg;
                        if (from_reg < limit_reg && rend <= {1'b0, limit_reg})
                        begin
                            st_next = ST_OK;
                            state_next = S_WRITE;
                        end
                    end
                    CMD_RESERVE:
                    begin
                        num_next = from_reg;
                        if (cnt_reg != '0 && rend <= {1'b0, limit_reg})
                        begin
                            if (found_reg && start_reg == from_reg)
                            begin
                                st_next = ST_OK;
                                state_next = S_WRITE;
                            end
                            else
                            begin
                                st_next = ST_TAKEN;
                            end
                        end
                    end
                    CMD_NEXT:
                    begin
                        st_next = ST_OK;
                        num_next = nfound_reg ? nxt_reg : limit_reg;
                    end
                    default:
                    begin
                        st_next = ST_INVALID;
                    end
                endcase
                addr_next = '0;
            end
            S_WRITE:
            begin
                // Read word n, then write it back in the cycle after.
                if (addr_reg < (WADDR_W+1)'(WORDS))
                begin
                    rd_en = 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
                else if (!rvld_reg)
                begin
                    state_next = S_DONE;
                end
                wr_en = rvld_reg;
            end
            S_DONE:
            begin
                if (!ovld_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg <= '0;
            limit_reg <= LIMIT_RESET;
            rvld_reg <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg <= addr_next;
            limit_reg <= limit_next;
            rvld_reg <= rd_en;
            if (out_load)
            begin
                ovld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            raddr_reg <= rd_addr[WADDR_W-1:0];
        end
        st_reg <= st_next;
        num_reg <= num_next;
        if (out_load)
        begin
            ost_reg <= st_reg;
            onum_reg <= num_reg;
            olim_reg <= limit_reg;
        end
        if (in_valid && in_ready)
        begin
            cmd_reg <= command;
            from_reg <= num_t'(from_number);
            fix_reg <= num_t'(fixed_number);
            cnt_reg <= num_t'(count);
            run_reg <= '0;
            found_reg <= 1'b0;
            nfound_reg <= 1'b0;
            start_reg <= '0;
            nxt_reg <= '0;
        end
        else if (state_reg == S_SCAN && rvld_reg)
        begin
            run_reg <= run_next;
            found_reg <= found_next;
            start_reg <= start_next;
            nfound_reg <= nfound_next;
            nxt_reg <= nxt_next;
        end
        if (state_reg == S_DECIDE)
        begin
            if (cmd_reg == CMD_FREE)
            begin
                wlo_reg <= from_reg;
                whi_reg <= from_reg + cnt_reg;
                wval_reg <= 1'b0;
            end
            else if (cmd_reg == CMD_RESERVE)
            begin
                wlo_reg <= from_reg;
                whi_reg <= from_reg + cnt_reg;
                wval_reg <= 1'b1;
            end
            else
            begin
                wlo_reg <= start_reg;
                whi_reg <= start_reg + cnt_reg;
                wval_reg <= 1'b1;
            end
        end
    end

    `IRA_ASSERT(a_no_accept_busy, clk, rst_n, (state_reg != S_IDLE) |-> !in_ready, "item accepted while busy")
    `IRA_ASSERT(a_limit_bound, clk, rst_n, limit_reg <= num_t'(MAP_BITS), "active limit past map")
    `IRA_ASSERT(a_limit_mono, clk, rst_n, (state_reg != S_DECIDE) |=> $stable(limit_reg), "limit moved outside decision")
    `IRA_ASSERT(a_done_out, clk, rst_n, out_load |=> out_valid, "result lost")
endmodule
